>>> hdl/tbrf_pkg.sv
// Shared types, codes and constants of the T=1 block receive framer.
package tbrf_pkg;

    // Milliseconds counted for each polled byte in the hunt phase.
    localparam int unsigned POLL_PERIOD_MS = 2;

    // Widths of the latched wait limit and the poll counter, and of the poll count in milliseconds.
    localparam int unsigned WAIT_W = 24;
    localparam int unsigned PROD_W = WAIT_W + $clog2(POLL_PERIOD_MS + 1);

    localparam logic [WAIT_W-1:0] POLL_MAX     = {WAIT_W{1'b1}};
    localparam logic [7:0]        NODE_ADDRESS = 8'h21;
    localparam logic [12:0]       MIN_CAPACITY = 13'd4;
    localparam logic [8:0]        HEADER_BASE  = 9'd2;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_WAIT_TIME  = 2'd0,
        CFG_CHECK_MODE = 2'd1,
        CFG_CAPACITY   = 2'd2
    } cfg_index_t;

    // Epilogue types.
    typedef enum logic [1:0] {
        CHK_NONE = 2'd0,
        CHK_LRC  = 2'd1,
        CHK_CRC  = 2'd2
    } check_mode_t;

    // Request kinds.
    typedef enum logic {
        REQ_START = 1'b0,
        REQ_BYTE  = 1'b1
    } req_kind_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_HUNTING    = 3'd0,
        ST_FRAME_BYTE = 3'd1,
        ST_COMPLETE   = 3'd2,
        ST_TIMEOUT    = 3'd3,
        ST_OVERFLOW   = 3'd4,
        ST_INVALID    = 3'd5,
        ST_STARTED    = 3'd6,
        ST_IGNORED    = 3'd7
    } status_t;

    // Receiver phases, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HUNT = 4'b0010,
        PH_HEAD = 4'b0100,
        PH_BODY = 4'b1000
    } phase_t;

    // Number of checksum bytes for an epilogue type; unused codes have none.
    function automatic logic [8:0] check_bytes(input logic [1:0] mode);
        logic [8:0] n;
        case (mode)
            CHK_LRC: n = 9'd1;
            CHK_CRC: n = 9'd2;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

>>> hdl/tbrf_req_if.sv
// Request channel: start or polled byte, with valid and ready.
interface tbrf_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;
    logic [7:0] wait_extension;

    modport source (output valid, output req_type, output rx_byte,
                    output wait_extension, input ready);
    modport sink (input valid, input req_type, input rx_byte,
                  input wait_extension, output ready);
endinterface

>>> hdl/tbrf_res_if.sv
// Result channel: one result per request, with valid and ready.
interface tbrf_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] out_byte;
    logic [8:0] byte_index;
    logic [8:0] frame_length;
    logic       frame_end;

    modport source (output valid, output status, output out_byte,
                    output byte_index, output frame_length, output frame_end,
                    input ready);
    modport sink (input valid, input status, input out_byte,
                  input byte_index, input frame_length, input frame_end,
                  output ready);
endinterface

>>> hdl/tbrf_cfg_if.sv
// Configuration write channel: register index and data, with valid and ready.
interface tbrf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/t1_block_receive_framer_core.sv
// Top level of the T=1 block receive framer: request register, framing logic, result register.
// A request taken into the request register moves into the result register when that register is free or being emptied.
// Throughput: one request per cycle while results are taken; the request register refills while the result is taken.
// A stalled result stays in the result register while one more request waits behind it.
// Reset (rst_n, asynchronous, active low) empties both registers, sets the receiver idle
// and loads the configuration defaults: wait 1000 ms, LRC epilogue, capacity 264.
module t1_block_receive_framer_core
    import tbrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tbrf_req_if.sink  req,
    tbrf_res_if.source res,
    tbrf_cfg_if.sink  cfg
);

    // Configuration registers.
    logic [15:0] wait_time_reg;
    logic [1:0]  check_mode_reg;
    logic [12:0] capacity_reg;

    // Request register.
    logic        in_valid_reg;
    logic        in_type_reg;
    logic [7:0]  in_byte_reg;
    logic [7:0]  in_ext_reg;

    // Receiver state.
    phase_t              phase_reg, phase_next;
    logic [WAIT_W-1:0]   wait_limit_reg, wait_limit_next;
    logic [WAIT_W-1:0]   poll_reg, poll_next;
    logic [8:0]          pos_reg, pos_next;
    logic [7:0]          info_reg, info_next;
    logic [8:0]          left_reg, left_next;

    // Result register.
    logic        out_valid_reg;
    status_t     status_reg, status_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [8:0]  index_reg, index_next;
    logic [8:0]  length_reg, length_next;
    logic        end_reg, end_next;

    // Intermediate values of the framing logic.
    logic [7:0]        ext_eff;
    logic [WAIT_W-1:0] poll_inc;
    logic [PROD_W-1:0] poll_ms;
    logic [8:0]        pos_inc;
    logic [8:0]        left_dec;
    logic [7:0]        info_new;
    logic [9:0]        total;

    logic fire;

    // A request is processed when the result register is free or being emptied.
    assign fire      = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || fire;
    assign cfg.ready = 1'b1;

    assign res.valid        = out_valid_reg;
    assign res.status       = status_reg;
    assign res.out_byte     = out_byte_reg;
    assign res.byte_index   = index_reg;
    assign res.frame_length = length_reg;
    assign res.frame_end    = end_reg;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_time_reg  <= 16'd1000;
            check_mode_reg <= CHK_LRC;
            capacity_reg   <= 13'd264;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_WAIT_TIME:  wait_time_reg  <= cfg.data;
                CFG_CHECK_MODE: check_mode_reg <= cfg.data[1:0];
                CFG_CAPACITY:   capacity_reg   <= cfg.data[12:0];
                default:        ;
            endcase
        end
    end

    // Shared arithmetic on the present state and request.
    always_comb
    begin
        ext_eff  = (in_ext_reg == 8'd0) ? 8'd1 : in_ext_reg;
        poll_inc = (poll_reg < POLL_MAX) ? poll_reg + 1'b1 : poll_reg;
        poll_ms  = PROD_W'(poll_inc) * PROD_W'(POLL_PERIOD_MS);
        pos_inc  = pos_reg + 9'd1;
        left_dec = (left_reg != 9'd0) ? left_reg - 9'd1 : 9'd0;
        info_new = (pos_reg == 9'd2) ? in_byte_reg : info_reg;
        total    = {1'b0, pos_inc} + {2'b00, info_new};
    end

    // Framing logic: next state and the result for the request in hand.
    always_comb
    begin
        phase_next      = phase_reg;
        wait_limit_next = wait_limit_reg;
        poll_next       = poll_reg;
        pos_next        = pos_reg;
        info_next       = info_reg;
        left_next       = left_reg;
        status_next     = ST_IGNORED;
        out_byte_next   = 8'd0;
        index_next      = 9'd0;
        length_next     = 9'd0;
        end_next        = 1'b0;

        if (in_type_reg == REQ_START)
        begin
            if (capacity_reg < MIN_CAPACITY)
            begin
                phase_next  = PH_IDLE;
                status_next = ST_INVALID;
                end_next    = 1'b1;
            end
            else
            begin
                wait_limit_next = WAIT_W'(wait_time_reg) * WAIT_W'(ext_eff);
                poll_next       = '0;
                pos_next        = 9'd0;
                info_next       = 8'd0;
                left_next       = 9'd0;
                phase_next      = PH_HUNT;
                status_next     = ST_STARTED;
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    status_next = ST_IGNORED;
                end
                PH_HUNT:
                begin
                    poll_next = poll_inc;
                    if (poll_ms >= PROD_W'(wait_limit_reg))
                    begin
                        phase_next  = PH_IDLE;
                        status_next = ST_TIMEOUT;
                        end_next    = 1'b1;
                    end
                    else if (in_byte_reg == NODE_ADDRESS)
                    begin
                        pos_next      = 9'd1;
                        left_next     = HEADER_BASE + check_bytes(check_mode_reg);
                        phase_next    = PH_HEAD;
                        status_next   = ST_FRAME_BYTE;
                        out_byte_next = in_byte_reg;
                    end
                    else
                    begin
                        status_next = ST_HUNTING;
                    end
                end
                PH_HEAD:
                begin
                    pos_next  = pos_inc;
                    left_next = left_dec;
                    info_next = info_new;
                    if (left_dec != 9'd0)
                    begin
                        status_next   = ST_FRAME_BYTE;
                        out_byte_next = in_byte_reg;
                        index_next    = pos_reg;
                    end
                    else if (13'(total) > capacity_reg)
                    begin
                        // The whole block, NAD included, would not fit.
                        phase_next  = PH_IDLE;
                        status_next = ST_OVERFLOW;
                        end_next    = 1'b1;
                    end
                    else if (info_new == 8'd0)
                    begin
                        // Empty information field: the header ends the block.
                        phase_next    = PH_IDLE;
                        status_next   = ST_COMPLETE;
                        out_byte_next = in_byte_reg;
                        index_next    = pos_reg;
                        length_next   = total[8:0];
                        end_next      = 1'b1;
                    end
                    else
                    begin
                        left_next     = {1'b0, info_new};
                        phase_next    = PH_BODY;
                        status_next   = ST_FRAME_BYTE;
                        out_byte_next = in_byte_reg;
                        index_next    = pos_reg;
                    end
                end
                PH_BODY:
                begin
                    pos_next      = pos_inc;
                    left_next     = left_dec;
                    out_byte_next = in_byte_reg;
                    index_next    = pos_reg;
                    if (left_dec == 9'd0)
                    begin
                        phase_next  = PH_IDLE;
                        status_next = ST_COMPLETE;
                        length_next = pos_inc;
                        end_next    = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_FRAME_BYTE;
                    end
                end
                default:
                begin
                    phase_next  = PH_IDLE;
                    status_next = ST_IGNORED;
                end
            endcase
        end
    end

    // Request register: loads whenever a request is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_type_reg <= req.req_type;
            in_byte_reg <= req.rx_byte;
            in_ext_reg  <= req.wait_extension;
        end
    end

    // Receiver state advances once per processed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            wait_limit_reg <= '0;
            poll_reg       <= '0;
            pos_reg        <= 9'd0;
            info_reg       <= 8'd0;
            left_reg       <= 9'd0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            wait_limit_reg <= wait_limit_next;
            poll_reg       <= poll_next;
            pos_reg        <= pos_next;
            info_reg       <= info_next;
            left_reg       <= left_next;
        end
    end

    // Result register: holds until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg   <= status_next;
            out_byte_reg <= out_byte_next;
            index_reg    <= index_next;
            length_reg   <= length_next;
            end_reg      <= end_next;
        end
    end

endmodule

>>> hdl/tbrf_checker.sv
// Port-level assertions for the T=1 block receive framer, bound to the top level.
module tbrf_checker
    import tbrf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] status,
    input logic [7:0] out_byte,
    input logic [8:0] byte_index,
    input logic [8:0] frame_length,
    input logic       frame_end
);

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status) && $stable(out_byte)
            && $stable(byte_index) && $stable(frame_length) && $stable(frame_end))
        else $error("stalled result changed");

    // The receive ends exactly on completion or one of the error results.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> frame_end == (status == ST_COMPLETE || status == ST_TIMEOUT
            || status == ST_OVERFLOW || status == ST_INVALID))
        else $error("frame_end does not match status");

    // Only frame bytes and the completing byte carry a byte and an index.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !(status == ST_FRAME_BYTE || status == ST_COMPLETE)
            |-> out_byte == 8'd0 && byte_index == 9'd0)
        else $error("byte fields set on a non-data result");

    // A frame length is reported with completion alone, and covers the last byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (status == ST_COMPLETE) ? (frame_length == byte_index + 9'd1)
            : (frame_length == 9'd0))
        else $error("frame_length inconsistent with status");

endmodule

bind t1_block_receive_framer_core tbrf_checker u_tbrf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .status       (res.status),
    .out_byte     (res.out_byte),
    .byte_index   (res.byte_index),
    .frame_length (res.frame_length),
    .frame_end    (res.frame_end)
);
